FILE: sv/nmea_pkg.sv
// Shared types, codes and helpers for the NMEA sentence checksum checker.
// Used by the channel interfaces, the step logic and the top level.
package nmea_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned NIB_W  = 4;
	localparam int unsigned STAT_W = 3;

	localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;  // '$'
	localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;  // '*'
	localparam logic [BYTE_W-1:0] CH_0      = 8'h30;
	localparam logic [BYTE_W-1:0] CH_9      = 8'h39;
	localparam logic [BYTE_W-1:0] CH_UA     = 8'h41;
	localparam logic [BYTE_W-1:0] CH_UF     = 8'h46;
	localparam logic [BYTE_W-1:0] CH_LA     = 8'h61;
	localparam logic [BYTE_W-1:0] CH_LF     = 8'h66;

	localparam logic [BYTE_W-1:0] MAX_BODY_LEN_RST = 8'd80;

	// Word kinds on the result channel
	localparam logic KIND_BODY = 1'b0;
	localparam logic KIND_END  = 1'b1;

	typedef enum logic [STAT_W-1:0] {
		ST_OK       = 3'd0,
		ST_MISMATCH = 3'd1,
		ST_EMPTY    = 3'd2,
		ST_BADHEX   = 3'd3,
		ST_TOOLONG  = 3'd4,
		ST_RESTART  = 3'd5,
		ST_CUTOFF   = 3'd6
	} status_t;

	typedef enum logic [3:0] {
		PH_IDLE = 4'b0001,
		PH_BODY = 4'b0010,
		PH_HEX1 = 4'b0100,
		PH_HEX2 = 4'b1000
	} phase_t;

	typedef struct packed {
		phase_t            phase;
		logic [BYTE_W-1:0] running_xor;
		logic [BYTE_W-1:0] body_count;
		logic [NIB_W-1:0]  high_nibble;
	} chk_state_t;

	typedef struct packed {
		logic              out_kind;
		logic [BYTE_W-1:0] body_byte;
		logic [STAT_W-1:0] end_status;
		logic [BYTE_W-1:0] computed_sum;
		logic [BYTE_W-1:0] received_sum;
	} chk_result_t;

	typedef struct packed {
		logic             ok;
		logic [NIB_W-1:0] value;
	} hex_digit_t;

	// Decode one ASCII hex digit, either case
	function automatic hex_digit_t hex_decode(input logic [BYTE_W-1:0] c);
		hex_digit_t d;
		logic [BYTE_W-1:0] diff;
		d = '0;
		diff = '0;
		if (c >= CH_0 && c <= CH_9) begin
			diff = c - CH_0;
			d.ok = 1'b1;
			d.value = diff[NIB_W-1:0];
		end else if (c >= CH_UA && c <= CH_UF) begin
			diff = c - CH_UA + 8'd10;
			d.ok = 1'b1;
			d.value = diff[NIB_W-1:0];
		end else if (c >= CH_LA && c <= CH_LF) begin
			diff = c - CH_LA + 8'd10;
			d.ok = 1'b1;
			d.value = diff[NIB_W-1:0];
		end
		return d;
	endfunction

endpackage

FILE: sv/nmea_if.sv
// Valid/ready channel interfaces for received bytes and checker results.
// Depends on nmea_pkg for field widths.
interface nmea_in_if;
	import nmea_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;
	logic              chunk_last;
	modport source (output valid, output rx_byte, output chunk_last, input ready);
	modport sink   (input valid, input rx_byte, input chunk_last, output ready);
endinterface

interface nmea_out_if;
	import nmea_pkg::*;
	logic              valid;
	logic              ready;
	logic              out_kind;
	logic [BYTE_W-1:0] body_byte;
	logic [STAT_W-1:0] end_status;
	logic [BYTE_W-1:0] computed_sum;
	logic [BYTE_W-1:0] received_sum;
	modport source (output valid, output out_kind, output body_byte, output end_status,
		output computed_sum, output received_sum, input ready);
	modport sink   (input valid, input out_kind, input body_byte, input end_status,
		input computed_sum, input received_sum, output ready);
endinterface

FILE: sv/nmea_step.sv
// Per-byte next-state and result logic of the sentence checker.
// Depends on nmea_pkg (state and result structs, hex decoder, codes).
module nmea_step (
	input  nmea_pkg::chk_state_t          cur,
	input  logic [nmea_pkg::BYTE_W-1:0]   rx_byte,
	input  logic                          chunk_last,
	input  logic [nmea_pkg::BYTE_W-1:0]   max_body_len,
	output nmea_pkg::chk_state_t          nxt,
	output logic                          emit,
	output nmea_pkg::chk_result_t         res
);
	import nmea_pkg::*;

	hex_digit_t hd;

	assign hd = hex_decode(rx_byte);

	always_comb begin
		nxt  = cur;
		emit = 1'b0;
		res  = '0;

		if (rx_byte == CH_DOLLAR) begin
			// restart: close an open sentence, then open a fresh one
			if (cur.phase != PH_IDLE) begin
				emit = 1'b1;
				res.out_kind = KIND_END;
				res.end_status = ST_RESTART;
				res.computed_sum = cur.running_xor;
			end
			nxt.phase = PH_BODY;
			nxt.running_xor = '0;
			nxt.body_count = '0;
			nxt.high_nibble = '0;
		end else begin
			unique case (cur.phase)
				PH_BODY: begin
					if (rx_byte == CH_STAR) begin
						if (cur.body_count == '0) begin
							emit = 1'b1;
							res.out_kind = KIND_END;
							res.end_status = ST_EMPTY;
							res.computed_sum = cur.running_xor;
							nxt.phase = PH_IDLE;
						end else begin
							nxt.phase = PH_HEX1;
						end
					end else if (cur.body_count >= max_body_len) begin
						emit = 1'b1;
						res.out_kind = KIND_END;
						res.end_status = ST_TOOLONG;
						res.computed_sum = cur.running_xor;
						nxt.phase = PH_IDLE;
					end else begin
						// accumulate the body byte, and forward it unless it ends the buffer
						nxt.running_xor = cur.running_xor ^ rx_byte;
						nxt.body_count = cur.body_count + 8'd1;
						if (!chunk_last) begin
							emit = 1'b1;
							res.out_kind = KIND_BODY;
							res.body_byte = rx_byte;
							res.computed_sum = cur.running_xor ^ rx_byte;
						end
					end
				end
				PH_HEX1: begin
					if (!hd.ok) begin
						emit = 1'b1;
						res.out_kind = KIND_END;
						res.end_status = ST_BADHEX;
						res.computed_sum = cur.running_xor;
						nxt.phase = PH_IDLE;
					end else begin
						nxt.high_nibble = hd.value;
						nxt.phase = PH_HEX2;
					end
				end
				PH_HEX2: begin
					emit = 1'b1;
					res.out_kind = KIND_END;
					res.computed_sum = cur.running_xor;
					if (!hd.ok) begin
						res.end_status = ST_BADHEX;
					end else begin
						res.received_sum = {cur.high_nibble, hd.value};
						res.end_status = ({cur.high_nibble, hd.value} == cur.running_xor)
							? ST_OK : ST_MISMATCH;
					end
					nxt.phase = PH_IDLE;
				end
				default: begin
					// idle: drop bytes outside a sentence
				end
			endcase
		end

		// buffer end abandons an open sentence
		if (chunk_last && nxt.phase != PH_IDLE) begin
			if (!emit) begin
				emit = 1'b1;
				res = '0;
				res.out_kind = KIND_END;
				res.end_status = ST_CUTOFF;
				res.computed_sum = nxt.running_xor;
			end
			nxt.phase = PH_IDLE;
		end
	end

endmodule

FILE: sv/nmea_sentence_checker_top.sv
// Top level of the NMEA sentence checksum checker: state, config and result registers.
// Depends on nmea_pkg, nmea_if (channel interfaces) and nmea_step.
//
//  channel  dir  word                                   accepted when
//  rx       in   rx_byte, chunk_last                    rx.valid && rx.ready
//  sent     out  out_kind, body_byte, end_status,       sent.valid && sent.ready
//                computed_sum, received_sum
//  cfg      in   cfg_wr_data (max_body_len)             cfg_wr_en
//
// One byte per cycle while rx.ready is high: each accepted word updates the sentence state, and an
// emitting word loads the result register in the same cycle, through the nmea_step logic.
// rx.ready is high while the result register is empty or being taken this cycle,
// so a stall on sent holds back at most one word.
// Reset brings the checker idle with max_body_len at 80.
module nmea_sentence_checker_top (
	input  logic                        clk,
	input  logic                        arst_n,
	nmea_in_if.sink                     rx,
	nmea_out_if.source                  sent,
	input  logic                        cfg_wr_en,
	input  logic [nmea_pkg::BYTE_W-1:0] cfg_wr_data
);
	import nmea_pkg::*;

	chk_state_t        state_q;
	chk_state_t        state_nxt;
	chk_result_t       res_q;
	chk_result_t       res_nxt;
	logic              res_valid_q;
	logic              emit;
	logic              in_acc;
	logic [BYTE_W-1:0] max_len_q;

	assign rx.ready = !res_valid_q || sent.ready;
	assign in_acc   = rx.valid && rx.ready;

	nmea_step u_step (
		.cur          (state_q),
		.rx_byte      (rx.rx_byte),
		.chunk_last   (rx.chunk_last),
		.max_body_len (max_len_q),
		.nxt          (state_nxt),
		.emit         (emit),
		.res          (res_nxt)
	);

	// hold the body length limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_BODY_LEN_RST;
		end else if (cfg_wr_en) begin
			max_len_q <= cfg_wr_data;
		end
	end

	// advance the sentence state on each accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase       <= PH_IDLE;
			state_q.running_xor <= '0;
			state_q.body_count  <= '0;
			state_q.high_nibble <= '0;
		end else if (in_acc) begin
			state_q <= state_nxt;
		end
	end

	// result valid: load on an emitting word, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (in_acc) begin
			res_valid_q <= emit;
		end else if (sent.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (in_acc && emit) begin
			res_q <= res_nxt;
		end
	end

	assign sent.valid        = res_valid_q;
	assign sent.out_kind     = res_q.out_kind;
	assign sent.body_byte    = res_q.body_byte;
	assign sent.end_status   = res_q.end_status;
	assign sent.computed_sum = res_q.computed_sum;
	assign sent.received_sum = res_q.received_sum;

endmodule
